// ----- hw/rtl/adjmq_pkg.sv -----
// Shared types, codes and constants for the adjacency matrix query block.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps
`default_nettype none

package adjmq_pkg;

  // Fixed field widths of the stream payloads.
  localparam int NODE_W     = 5;
  localparam int CNT_W      = 6;
  localparam int WEIGHT_W   = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // Defaults for the top-level parameters.
  localparam int MAX_NODES_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Value of node_count after reset.
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

  // Input command codes carried on s_tuser.
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_NEIGH   = 2'd1;
  localparam logic [1:0] CMD_SOURCES = 2'd2;
  localparam logic [1:0] CMD_SINKS   = 2'd3;

  // Result kinds carried on m_tuser.
  typedef enum logic [2:0] {
    KIND_SUCC     = 3'd0,
    KIND_PRED     = 3'd1,
    KIND_SOURCE   = 3'd2,
    KIND_SINK     = 3'd3,
    KIND_NONE     = 3'd4,
    KIND_NOTFOUND = 3'd5
  } kind_t;

  // Operations handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_LOAD     = 3'd0,
    OP_NEIGH    = 3'd1,
    OP_SOURCES  = 3'd2,
    OP_SINKS    = 3'd3,
    OP_NOTFOUND = 3'd4,
    OP_EMPTY    = 3'd5
  } op_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_FLUSH = 2'd2
  } state_t;

  // One classified operation in the queue.
  typedef struct packed {
    op_t                 op;
    logic [NODE_W-1:0]   row;
    logic [NODE_W-1:0]   col;
    logic [WEIGHT_W-1:0] weight;
    logic [CNT_W-1:0]    n;
  } q_entry_t;

  // A Q8.8 weight counts as an edge when it is above zero.
  function automatic logic weight_positive(input logic [WEIGHT_W-1:0] w);
    return (w != '0) && !w[WEIGHT_W-1];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/adjmq_front.sv -----
// Front end: holds the node_count register, decodes input beats and
// classifies them into queue operations. Depends on adjmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adjmq_front #(
  parameter int MAX_NODES = adjmq_pkg::MAX_NODES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wen,
  input  wire logic [adjmq_pkg::CNT_W-1:0]         cfg_wdata,
  input  wire logic                                s_tvalid,
  output      logic                                s_tready,
  input  wire logic [adjmq_pkg::IN_DATA_W-1:0]     s_tdata,
  input  wire logic [1:0]                          s_tuser,
  output      logic                                q_push,
  output      adjmq_pkg::q_entry_t                 q_din,
  input  wire logic                                q_full
);
  import adjmq_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

  logic [CNT_W-1:0]    node_count;
  logic [CNT_W-1:0]    n_eff;
  logic [NODE_W-1:0]   row;
  logic [NODE_W-1:0]   col;
  logic [WEIGHT_W-1:0] weight;
  logic                drop;
  op_t                 op;

  // Node count register; the user must write it only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (cfg_wen) begin
      node_count <= cfg_wdata;
    end
  end

  // Counts above the matrix size act as the matrix size.
  assign n_eff = (node_count > MAX_CNT) ? MAX_CNT : node_count;

  // Field unpacking of the input beat.
  assign row    = s_tdata[NODE_W-1:0];
  assign col    = s_tdata[2*NODE_W-1:NODE_W];
  assign weight = s_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W];

  // Classify the beat; a load outside the matrix is dropped.
  always_comb begin
    op   = OP_LOAD;
    drop = 1'b0;
    case (s_tuser)
      CMD_LOAD: begin
        op   = OP_LOAD;
        drop = ({1'b0, row} >= MAX_CNT) || ({1'b0, col} >= MAX_CNT);
      end
      CMD_NEIGH: begin
        op = ({1'b0, row} >= n_eff) ? OP_NOTFOUND : OP_NEIGH;
      end
      CMD_SOURCES: begin
        op = (n_eff == '0) ? OP_EMPTY : OP_SOURCES;
      end
      CMD_SINKS: begin
        op = (n_eff == '0) ? OP_EMPTY : OP_SINKS;
      end
      default: begin
        op = OP_LOAD;
      end
    endcase
  end

  assign s_tready     = !q_full;
  assign q_push       = s_tvalid && s_tready && !drop;
  assign q_din.op     = op;
  assign q_din.row    = row;
  assign q_din.col    = col;
  assign q_din.weight = weight;
  assign q_din.n      = n_eff;

endmodule

`default_nettype wire

// ----- hw/rtl/adjmq_fifo.sv -----
// Short operation queue between the front end and the back end.
// Depends on adjmq_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module adjmq_fifo #(
  parameter int DEPTH = adjmq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire adjmq_pkg::q_entry_t  din,
  output      logic                 full,
  input  wire logic                 pop,
  output      adjmq_pkg::q_entry_t  dout,
  output      logic                 empty
);
  import adjmq_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        slots [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign dout    = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/adjmq_back.sv -----
// Back end: weight memory, scan sequencer and output register.
// Depends on adjmq_pkg; fed by adjmq_fifo.
`timescale 1ns / 1ps
`default_nettype none

module adjmq_back #(
  parameter int MAX_NODES = adjmq_pkg::MAX_NODES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire adjmq_pkg::q_entry_t                 q_head,
  input  wire logic                                q_empty,
  output      logic                                q_pop,
  output      logic                                m_tvalid,
  input  wire logic                                m_tready,
  output      logic [adjmq_pkg::OUT_DATA_W-1:0]    m_tdata,
  output      logic                                m_tlast,
  output      logic [2:0]                          m_tuser
);
  import adjmq_pkg::*;

  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);

  // Sequencer state and query parameters.
  state_t              state;
  state_t              state_next;
  op_t                 sop;
  logic [NODE_W-1:0]   qnode;
  logic [CNT_W-1:0]    n_m1;
  logic                phase;
  logic [NODE_W-1:0]   oc;
  logic [NODE_W-1:0]   ic;
  logic                issue_done;

  // Read stage.
  logic [WEIGHT_W-1:0] wmem [DEPTH];
  logic                rd_valid;
  logic [WEIGHT_W-1:0] rd_data;
  kind_t               rd_kind;
  logic [NODE_W-1:0]   rd_node;
  logic                rd_group_end;
  logic                rd_scan_end;

  // Evaluation and pending result.
  logic                found_acc;
  logic                pend_valid;
  kind_t               pend_kind;
  logic [NODE_W-1:0]   pend_node;
  logic [WEIGHT_W-1:0] pend_weight;

  // Output register.
  logic                out_valid;
  kind_t               out_kind;
  logic [NODE_W-1:0]   out_node;
  logic [WEIGHT_W-1:0] out_weight;
  logic                out_last;

  // Control.
  logic                out_free;
  logic                is_nb;
  logic                rd_pos;
  logic                hit;
  logic                advance;
  logic                issue;
  logic                start;
  logic                mem_we;
  logic                single_push;
  logic                eval_push;
  logic                flush_push;
  logic                head_scan;
  logic                head_single;
  logic                ic_last;
  logic                oc_last;
  logic [NODE_W-1:0]   iss_row;
  logic [NODE_W-1:0]   iss_col;
  kind_t               iss_kind;
  logic [NODE_W-1:0]   iss_node;
  logic                iss_scan_end;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;

  assign out_free    = !out_valid || m_tready;
  assign is_nb       = (sop == OP_NEIGH);
  assign head_scan   = (q_head.op == OP_NEIGH) || (q_head.op == OP_SOURCES) ||
                       (q_head.op == OP_SINKS);
  assign head_single = (q_head.op == OP_NOTFOUND) || (q_head.op == OP_EMPTY);

  // Evaluate the entry in the read stage.
  assign rd_pos  = weight_positive(rd_data);
  assign hit     = rd_valid && (is_nb ? rd_pos : (rd_group_end && !(found_acc || rd_pos)));
  assign advance = rd_valid && !(hit && pend_valid && !out_free);

  // Address generation for the next read.
  assign ic_last = ({1'b0, ic} == n_m1);
  assign oc_last = ({1'b0, oc} == n_m1);

  always_comb begin
    iss_row      = oc;
    iss_col      = ic;
    iss_kind     = KIND_SINK;
    iss_node     = oc;
    iss_scan_end = ic_last && oc_last;
    case (sop)
      OP_NEIGH: begin
        iss_row      = phase ? ic : qnode;
        iss_col      = phase ? qnode : ic;
        iss_kind     = phase ? KIND_PRED : KIND_SUCC;
        iss_node     = ic;
        iss_scan_end = phase && ic_last;
      end
      OP_SOURCES: begin
        iss_row  = ic;
        iss_col  = oc;
        iss_kind = KIND_SOURCE;
      end
      default: begin
        iss_row  = oc;
        iss_col  = ic;
        iss_kind = KIND_SINK;
      end
    endcase
  end

  assign raddr = AW'(iss_row) * AW'(MAX_NODES) + AW'(iss_col);
  assign waddr = AW'(q_head.row) * AW'(MAX_NODES) + AW'(q_head.col);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty && head_scan) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (advance && rd_scan_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    single_push = 1'b0;
    start       = 1'b0;
    issue       = 1'b0;
    eval_push   = 1'b0;
    flush_push  = 1'b0;
    case (state)
      ST_IDLE: begin
        q_pop       = !q_empty && (!head_single || out_free);
        mem_we      = q_pop && (q_head.op == OP_LOAD);
        single_push = q_pop && head_single;
        start       = q_pop && head_scan;
      end
      ST_SCAN: begin
        issue     = !issue_done && (!rd_valid || advance);
        eval_push = advance && hit && pend_valid;
      end
      ST_FLUSH: begin
        flush_push = out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Sequencer state and scan counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issue_done <= 1'b1;
    end else begin
      state <= state_next;
      if (start) begin
        issue_done <= 1'b0;
      end else if (issue && ic_last && (!is_nb || phase) && (is_nb || oc_last)) begin
        issue_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sop   <= q_head.op;
      qnode <= q_head.row;
      n_m1  <= q_head.n - 1'b1;
      phase <= 1'b0;
      oc    <= '0;
      ic    <= '0;
    end else if (issue) begin
      if (ic_last) begin
        ic <= '0;
        if (is_nb) begin
          phase <= 1'b1;
        end else if (!oc_last) begin
          oc <= oc + 1'b1;
        end
      end else begin
        ic <= ic + 1'b1;
      end
    end
  end

  // Weight memory: one write port for loads, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wmem[waddr] <= q_head.weight;
    end
    if (issue) begin
      rd_data <= wmem[raddr];
    end
  end

  // Read stage valid and tags.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (issue) begin
      rd_valid <= 1'b1;
    end else if (advance) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_kind      <= iss_kind;
      rd_node      <= iss_node;
      rd_group_end <= ic_last;
      rd_scan_end  <= iss_scan_end;
    end
  end

  // Per-node edge flag for source and sink scans.
  always_ff @(posedge clk) begin
    if (rst) begin
      found_acc <= 1'b0;
    end else if (start) begin
      found_acc <= 1'b0;
    end else if (advance && !is_nb) begin
      found_acc <= rd_group_end ? 1'b0 : (found_acc || rd_pos);
    end
  end

  // One result is held back so the final one can carry tlast.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (start || flush_push) begin
      pend_valid <= 1'b0;
    end else if (advance && hit) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      pend_kind   <= rd_kind;
      pend_node   <= rd_node;
      pend_weight <= is_nb ? rd_data : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (single_push || eval_push || flush_push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (single_push) begin
      out_kind   <= (q_head.op == OP_NOTFOUND) ? KIND_NOTFOUND : KIND_NONE;
      out_node   <= (q_head.op == OP_NOTFOUND) ? q_head.row : '0;
      out_weight <= '0;
      out_last   <= 1'b1;
    end else if (eval_push) begin
      out_kind   <= pend_kind;
      out_node   <= pend_node;
      out_weight <= pend_weight;
      out_last   <= 1'b0;
    end else if (flush_push) begin
      out_kind   <= pend_valid ? pend_kind : KIND_NONE;
      out_node   <= pend_valid ? pend_node : '0;
      out_weight <= pend_valid ? pend_weight : '0;
      out_last   <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_DATA_W - NODE_W - WEIGHT_W){1'b0}}, out_weight, out_node};

endmodule

`default_nettype wire

// ----- hw/rtl/adjacency_matrix_neighbour_query.sv -----
// Adjacency matrix neighbour query: top level joining front end, queue and
// back end. Depends on adjmq_pkg, adjmq_front, adjmq_fifo and adjmq_back.
//
// Usage: beats on the s_ side carry a command in s_tuser (load weight,
// neighbour query, list sources, list sinks) and the node and weight fields
// in s_tdata. Loads write one entry of the weight matrix and give no
// result. Queries give one or more result beats on the m_ side, the kind in
// m_tuser, node and weight in m_tdata, m_tlast on the final beat of a query.
// The node_count register is written through cfg_wen/cfg_wdata; the user
// must write it only while idle; the block itself does not enforce this.
// Flow: beats enter a four-deep operation queue, so the input side keeps
// taking beats while a query runs until the queue fills. A neighbour query
// reads 2*n matrix entries and a source or sink query n*n entries, one entry
// per cycle through the single read port of the weight memory, pausing
// while the output stalls; a missing node or no nodes gives one result beat.
// When the receiver stalls, the output register holds its beat and the scan
// pauses in place. Reset clears the queue, the sequencer and the output
// register and sets node_count to 32; the weight memory is not cleared and
// every entry must be loaded before it is scanned.
`timescale 1ns / 1ps
`default_nettype none

module adjacency_matrix_neighbour_query #(
  parameter int MAX_NODES   = adjmq_pkg::MAX_NODES_DEF,
  parameter int QUEUE_DEPTH = adjmq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wen,
  input  wire logic [adjmq_pkg::CNT_W-1:0]       cfg_wdata,   // node_count
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  // row_node[4:0], col_node[9:5], edge_weight[25:10], zero fill [31:26]
  input  wire logic [adjmq_pkg::IN_DATA_W-1:0]   s_tdata,
  input  wire logic [1:0]                        s_tuser,     // cmd[1:0]
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  // node_id[4:0], weight_out[20:5], zero fill [23:21]
  output      logic [adjmq_pkg::OUT_DATA_W-1:0]  m_tdata,
  output      logic                              m_tlast,
  output      logic [2:0]                        m_tuser      // kind[2:0]
);
  import adjmq_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  q_entry_t q_din;
  q_entry_t q_head;

  // Decode and classify incoming beats.
  adjmq_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_push    (q_push),
    .q_din     (q_din),
    .q_full    (q_full)
  );

  // Operation queue.
  adjmq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  // Matrix storage and scans.
  adjmq_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTH
  // The front end never pushes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("operation queue pushed while full");

  // The back end never pops an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("operation queue popped while empty");

  // Single-beat answers always close their query.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_NONE || m_tuser == KIND_NOTFOUND)) |-> m_tlast)
    else $error("none or not-found result without tlast");

  // Only neighbour results carry a weight.
  a_zero_weight: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != KIND_SUCC && m_tuser != KIND_PRED) |->
      (m_tdata[20:5] == '0))
    else $error("non-neighbour result with nonzero weight");
`endif

endmodule

`default_nettype wire
